FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MWBQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MWBQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/mwbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mwbq_pkg;

   localparam int MAX_WRITERS = 8;
   localparam int BATCH_DEPTH = 16;
   localparam int MAX_PENDING = 16;
   localparam int ELEM_WIDTH  = 64;

   localparam int POOL_SLOTS  = MAX_WRITERS + 2 * MAX_PENDING;
   localparam int RING_SIZE   = 2 * MAX_PENDING;
   localparam int STORE_DEPTH = POOL_SLOTS * BATCH_DEPTH;

   localparam int WID_W  = (MAX_WRITERS > 1) ? $clog2(MAX_WRITERS) : 1;
   localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int RING_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
   localparam int FILL_W = $clog2(BATCH_DEPTH + 1);
   localparam int CNT_W  = $clog2(RING_SIZE + 1);
   localparam int PEND_W = $clog2(MAX_PENDING + 1);
   localparam int DONE_W = $clog2(MAX_WRITERS + 1);
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int HELD_W = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W  = RING_W + 2;

   // Field widths of the ports
   localparam int ACTION_W    = 2;
   localparam int ID_W        = 3;
   localparam int DATA_W      = 64;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 10;
   localparam int PB_W        = 5;
   localparam int AW_W        = 4;
   localparam int LEN_W       = 5;
   localparam int LIM_W       = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE,
      ACT_FLUSH,
      ACT_TERM,
      ACT_READ
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BLOCKED,
      ST_IGNORED,
      ST_EMPTY,
      ST_DONE
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WRITERS,
      CSR_LENGTH,
      CSR_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [AW_W-1:0]  active_writers;
      logic [LEN_W-1:0] batch_length;
      logic [LIM_W-1:0] pending_limit;
   } cfg_type;

   typedef struct packed {
      logic                  we;
      logic                  re;
      logic [ADDR_W-1:0]     addr;
      logic [ELEM_WIDTH-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      status_type        status;
      logic              rd_ok;
      logic [HELD_W-1:0] occupancy;
      logic [PEND_W-1:0] pending;
      logic              can_read;
      logic              finished;
   } res_type;

endpackage
`default_nettype wire

FILE: sv/mwbq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mwbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]                wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic      [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/mwbq_core.sv
`timescale 1ns / 1ps
`default_nettype none
module mwbq_core import mwbq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [ACTION_W-1:0]   action,
   input  wire logic [ID_W-1:0]       writer_id,
   input  wire logic [DATA_W-1:0]     element,
   input  wire cfg_type               cfg,
   output mem_req_type                mem,
   output res_type                    res
);

   // Writer side
   logic              holds_ff [MAX_WRITERS];
   logic              holds_in [MAX_WRITERS];
   logic [SLOT_W-1:0] wslot_ff [MAX_WRITERS];
   logic [SLOT_W-1:0] wslot_in [MAX_WRITERS];
   logic [FILL_W-1:0] wfill_ff [MAX_WRITERS];
   logic [FILL_W-1:0] wfill_in [MAX_WRITERS];
   logic              done_ff  [MAX_WRITERS];
   logic              done_in  [MAX_WRITERS];
   logic              free_ff  [POOL_SLOTS];
   logic              free_in  [POOL_SLOTS];

   // Order ring: slot and fill of each handed-over batch
   logic [SLOT_W-1:0] ring_slot_ff [RING_SIZE];
   logic [FILL_W-1:0] ring_fill_ff [RING_SIZE];
   logic              ring_we;
   logic [RING_W-1:0] ring_widx;
   logic [SLOT_W-1:0] ring_wslot;
   logic [FILL_W-1:0] ring_wfill;

   // Reader side
   logic [RING_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [FILL_W-1:0] off_ff, off_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [FILL_W-1:0] cur_fill_ff, cur_fill_in;
   logic              latch_ff, latch_in;
   logic [DONE_W-1:0] seen_ff, seen_in;
   logic [HELD_W-1:0] held_ff, held_in;

   logic [DONE_W-1:0] eff_w;
   logic [FILL_W-1:0] eff_len;
   logic [PEND_W-1:0] eff_lim;
   logic [WID_W-1:0]  wi;
   logic              wid_bad;
   logic              cap_fail;
   logic [SUM_W-1:0]  tail_sum;
   logic [RING_W-1:0] tail;
   logic [RING_W-1:0] head_inc;
   logic [RING_W-1:0] rd_idx;
   logic [SLOT_W-1:0] first_free;
   logic              any_free;
   logic [DONE_W-1:0] recount;
   logic              go;
   logic              need_new;
   logic [SLOT_W-1:0] slot_sel;
   logic [FILL_W-1:0] fill_sel;
   logic [CNT_W-1:0]  cnt_n;
   action_type        op;

   assign op = action_type'(action);
   assign wi = WID_W'(writer_id);

   always_comb begin
      if (cfg.active_writers == '0) begin
         eff_w = DONE_W'(1);
      end else if (32'(cfg.active_writers) > MAX_WRITERS) begin
         eff_w = DONE_W'(MAX_WRITERS);
      end else begin
         eff_w = DONE_W'(cfg.active_writers);
      end
      if (cfg.batch_length == '0) begin
         eff_len = FILL_W'(1);
      end else if (32'(cfg.batch_length) > BATCH_DEPTH) begin
         eff_len = FILL_W'(BATCH_DEPTH);
      end else begin
         eff_len = FILL_W'(cfg.batch_length);
      end
      if (cfg.pending_limit == '0 || 32'(cfg.pending_limit) > MAX_PENDING) begin
         eff_lim = PEND_W'(MAX_PENDING);
      end else begin
         eff_lim = PEND_W'(cfg.pending_limit);
      end
   end

   assign wid_bad  = 32'(writer_id) >= 32'(eff_w);
   assign cap_fail = (pend_ff >= eff_lim) ||
                     ((SUM_W'(count_ff) + SUM_W'(pend_ff)) >= SUM_W'(RING_SIZE));
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff) + SUM_W'(pend_ff);
   assign tail     = (tail_sum >= SUM_W'(RING_SIZE)) ? RING_W'(tail_sum - SUM_W'(RING_SIZE))
                                                     : RING_W'(tail_sum);
   assign head_inc = (head_ff == RING_W'(RING_SIZE - 1)) ? '0 : head_ff + RING_W'(1);
   // An exhausted head batch is skipped, so the next batch sits one place on
   assign rd_idx   = (count_ff != '0) ? head_inc : head_ff;

   always_comb begin
      first_free = '0;
      any_free   = 1'b0;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            first_free = SLOT_W'(i);
            any_free   = 1'b1;
         end
      end
   end

   always_comb begin
      recount = '0;
      for (int i = 0; i < MAX_WRITERS; i++) begin
         if (done_ff[i] && (32'(i) < 32'(eff_w))) begin
            recount = recount + DONE_W'(1);
         end
      end
   end

   always_comb begin
      holds_in    = holds_ff;
      wslot_in    = wslot_ff;
      wfill_in    = wfill_ff;
      done_in     = done_ff;
      free_in     = free_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      off_in      = off_ff;
      cur_slot_in = cur_slot_ff;
      cur_fill_in = cur_fill_ff;
      latch_in    = latch_ff;
      seen_in     = seen_ff;
      held_in     = held_ff;
      ring_we     = 1'b0;
      ring_widx   = tail;
      ring_wslot  = wslot_ff[wi];
      ring_wfill  = wfill_ff[wi];
      mem         = '0;
      mem.wdata   = element[ELEM_WIDTH-1:0];
      res.status  = ST_OK;
      res.rd_ok   = 1'b0;
      go          = 1'b0;
      need_new    = 1'b0;
      slot_sel    = wslot_ff[wi];
      fill_sel    = wfill_ff[wi];
      cnt_n       = '0;

      if (fire) begin
         if (op == ACT_READ) begin
            if (count_ff != '0 && off_ff < cur_fill_ff) begin
               mem.re   = 1'b1;
               mem.addr = ADDR_W'(cur_slot_ff) * ADDR_W'(BATCH_DEPTH) + ADDR_W'(off_ff);
               off_in   = off_ff + FILL_W'(1);
               res.rd_ok = 1'b1;
            end else begin
               if (count_ff != '0) begin
                  // drop the exhausted batch and return its slot
                  free_in[cur_slot_ff] = 1'b1;
                  head_in = head_inc;
                  cnt_n   = count_ff - CNT_W'(1);
               end
               off_in = '0;
               if (cnt_n != '0) begin
                  count_in = cnt_n;
                  res.rd_ok = 1'b1;
               end else begin
                  // take the whole pending list
                  count_in = CNT_W'(pend_ff);
                  pend_in  = '0;
                  latch_in = 1'b0;
                  seen_in  = recount;
                  res.rd_ok = pend_ff != '0;
               end
               if (res.rd_ok) begin
                  mem.re      = 1'b1;
                  mem.addr    = ADDR_W'(ring_slot_ff[rd_idx]) * ADDR_W'(BATCH_DEPTH);
                  cur_slot_in = ring_slot_ff[rd_idx];
                  cur_fill_in = ring_fill_ff[rd_idx];
                  off_in      = FILL_W'(1);
               end
            end
            if (res.rd_ok) begin
               if (held_ff != '0) begin
                  held_in = held_ff - HELD_W'(1);
               end
            end else if (seen_in == eff_w && held_in == '0) begin
               res.status = ST_DONE;
            end else begin
               res.status = ST_EMPTY;
            end
         end else if (wid_bad) begin
            res.status = ST_IGNORED;
         end else if (op == ACT_WRITE) begin
            if (done_ff[wi]) begin
               res.status = ST_IGNORED;
            end else begin
               go       = 1'b1;
               need_new = !holds_ff[wi];
               if (holds_ff[wi] && wfill_ff[wi] >= eff_len) begin
                  if (latch_ff) begin
                     res.status = ST_BLOCKED;
                     go = 1'b0;
                  end else if (cap_fail) begin
                     latch_in   = 1'b1;
                     res.status = ST_BLOCKED;
                     go = 1'b0;
                  end else begin
                     ring_we      = 1'b1;
                     pend_in      = pend_ff + PEND_W'(1);
                     holds_in[wi] = 1'b0;
                     need_new     = 1'b1;
                  end
               end
               if (go && need_new) begin
                  if (!any_free) begin
                     res.status = ST_BLOCKED;
                     go = 1'b0;
                  end else begin
                     free_in[first_free] = 1'b0;
                     wslot_in[wi]  = first_free;
                     holds_in[wi]  = 1'b1;
                     slot_sel      = first_free;
                     fill_sel      = '0;
                  end
               end
               if (go) begin
                  if (fill_sel >= FILL_W'(BATCH_DEPTH)) begin
                     res.status = ST_BLOCKED;
                  end else begin
                     mem.we       = 1'b1;
                     mem.addr     = ADDR_W'(slot_sel) * ADDR_W'(BATCH_DEPTH) +
                                    ADDR_W'(fill_sel);
                     wfill_in[wi] = fill_sel + FILL_W'(1);
                     held_in      = held_ff + HELD_W'(1);
                  end
               end
            end
         end else begin
            if (op == ACT_TERM) begin
               done_in[wi] = 1'b1;
            end
            if (holds_ff[wi] && wfill_ff[wi] != '0) begin
               if (latch_ff) begin
                  res.status = ST_BLOCKED;
               end else if (cap_fail) begin
                  latch_in   = 1'b1;
                  res.status = ST_BLOCKED;
               end else begin
                  ring_we      = 1'b1;
                  pend_in      = pend_ff + PEND_W'(1);
                  holds_in[wi] = 1'b0;
               end
            end
         end
      end

      res.occupancy = held_in;
      res.pending   = pend_in;
      res.can_read  = count_in != '0;
      res.finished  = (seen_in == eff_w) && (held_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WRITERS; i++) begin
            holds_ff[i] <= 1'b0;
            done_ff[i]  <= 1'b0;
         end
         for (int i = 0; i < POOL_SLOTS; i++) begin
            free_ff[i] <= 1'b1;
         end
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
         off_ff   <= '0;
         latch_ff <= 1'b0;
         seen_ff  <= '0;
         held_ff  <= '0;
      end else begin
         holds_ff <= holds_in;
         done_ff  <= done_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         off_ff   <= off_in;
         latch_ff <= latch_in;
         seen_ff  <= seen_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      wslot_ff    <= wslot_in;
      wfill_ff    <= wfill_in;
      cur_slot_ff <= cur_slot_in;
      cur_fill_ff <= cur_fill_in;
      if (ring_we) begin
         ring_slot_ff[ring_widx] <= ring_wslot;
         ring_fill_ff[ring_widx] <= ring_wfill;
      end
   end

endmodule
`default_nettype wire

FILE: sv/multi_writer_batching_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes the input register, then the result register, before its
// result is offered.
// Throughput: one item per cycle while results are taken; the single-pass operation
// stage and the one-port element store each take one item per clock.
// Reset (synchronous, active high) empties every batch, the pending list and
// the reader chain, and restores the registers to 1 writer, 16, 0; no clearing pass.
module multi_writer_batching_queue import mwbq_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [ACTION_W-1:0]    req_action,
   input  wire logic [ID_W-1:0]        req_writer_id,
   input  wire logic [DATA_W-1:0]      req_element,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [DATA_W-1:0]           rsp_read_data,
   output logic [OCC_W-1:0]            rsp_occupancy,
   output logic [PB_W-1:0]             rsp_pending_batches,
   output logic                        rsp_can_read,
   output logic                        rsp_all_finished,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic                in_v_ff, in_v_in;
   logic [ACTION_W-1:0] in_act_ff;
   logic [ID_W-1:0]     in_wid_ff;
   logic [DATA_W-1:0]   in_elem_ff;
   logic                res_v_ff, res_v_in;
   res_type             res_ff;
   res_type             res_now;
   cfg_type             cfg_ff, cfg_in;
   mem_req_type         mem;
   logic [ELEM_WIDTH-1:0] ram_q;
   logic                adv;
   logic                fire;

   assign adv       = !res_v_ff || rsp_ready;
   assign fire      = in_v_ff && adv;
   assign req_ready = !in_v_ff || adv;
   assign csr_ready = 1'b1;
   assign in_v_in   = (req_valid && req_ready) || (in_v_ff && !fire);
   assign res_v_in  = fire || (res_v_ff && !rsp_ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_WRITERS: cfg_in.active_writers = AW_W'(csr_data);
            CSR_LENGTH:  cfg_in.batch_length   = LEN_W'(csr_data);
            CSR_LIMIT:   cfg_in.pending_limit  = LIM_W'(csr_data);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         res_v_ff <= 1'b0;
         cfg_ff.active_writers <= AW_W'(1);
         cfg_ff.batch_length   <= LEN_W'(16);
         cfg_ff.pending_limit  <= '0;
      end else begin
         in_v_ff  <= in_v_in;
         res_v_ff <= res_v_in;
         cfg_ff   <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_act_ff  <= req_action;
         in_wid_ff  <= req_writer_id;
         in_elem_ff <= req_element;
      end
      if (fire) begin
         res_ff <= res_now;
      end
   end

   mwbq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .action    (in_act_ff),
      .writer_id (in_wid_ff),
      .element   (in_elem_ff),
      .cfg       (cfg_ff),
      .mem       (mem),
      .res       (res_now)
   );

   mwbq_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem.we),
      .wr_addr (mem.addr),
      .wr_data (mem.wdata),
      .rd_en   (mem.re),
      .rd_addr (mem.addr),
      .rd_data (ram_q)
   );

   assign rsp_valid           = res_v_ff;
   assign rsp_status          = res_ff.status;
   assign rsp_read_data       = res_ff.rd_ok ? DATA_W'(ram_q) : '0;
   assign rsp_occupancy       = OCC_W'(res_ff.occupancy);
   assign rsp_pending_batches = PB_W'(res_ff.pending);
   assign rsp_can_read        = res_ff.can_read;
   assign rsp_all_finished    = res_ff.finished;

endmodule
`default_nettype wire

FILE: sv/mwbq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mwbq_checker import mwbq_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [STATUS_W-1:0]    rsp_status,
   input wire logic [DATA_W-1:0]      rsp_read_data,
   input wire logic [OCC_W-1:0]       rsp_occupancy,
   input wire logic                   rsp_all_finished
);

   `MWBQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_data), "result changed while stalled")
   `MWBQ_ASSERT(a_data_zero, rsp_valid && rsp_status != ST_OK |-> rsp_read_data == '0, "read data set on a failed item")
   `MWBQ_ASSERT(a_finish_empty, rsp_valid && rsp_all_finished |-> rsp_occupancy == '0, "finished with elements held")
   `MWBQ_ASSERT_ALWAYS(a_reset_idle, $past(reset) && !reset |-> !rsp_valid, "result offered straight after reset")

endmodule

bind multi_writer_batching_queue mwbq_checker u_mwbq_checker (.*);
`default_nettype wire
